FILE: src/wscc_pkg.sv
// shared constants, types and helpers of the word suffix class counter
package wscc_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int MAX_SUFFIX = 8;
   localparam int COUNT_WIDTH = 16;

   localparam int CODE_BITS = 5;
   localparam int TAIL_W = CODE_BITS * MAX_SUFFIX;
   localparam int SEEN_W = $clog2(MAX_SUFFIX + 1);
   localparam int LETTERS_W = 40;
   localparam int LEN_W = 4;
   localparam int CLASS_W = 2;
   localparam int INDEX_W = 5;
   localparam int TOTAL_W = 16;
   localparam int WIDE_W = 64;
   localparam int CMP_W = 6;

   localparam logic CMD_TEXT = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   localparam logic [CLASS_W-1:0] CLASS_NOUN = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_VERB = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_ADJECTIVE = 2'd2;

   localparam logic [7:0] CHAR_DOT = 8'h2E;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   typedef struct packed {
      logic                 valid;
      logic [CLASS_W-1:0]   cls;
      logic [LEN_W-1:0]     len;
      logic [LETTERS_W-1:0] letters;
   } entry_type;

   typedef struct packed {
      logic [TAIL_W-1:0] letters;
      logic [SEEN_W-1:0] seen;
   } tail_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] noun;
      logic [COUNT_WIDTH-1:0] verb;
      logic [COUNT_WIDTH-1:0] adjective;
   } totals_type;

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   endfunction

   function automatic logic [TAIL_W-1:0] fit_letters(input logic [LETTERS_W-1:0] l);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(l);
      return w[TAIL_W-1:0];
   endfunction

   function automatic logic [TOTAL_W-1:0] fit_total(input logic [COUNT_WIDTH-1:0] c);
      logic [WIDE_W-1:0] w;
      w = WIDE_W'(c);
      return w[TOTAL_W-1:0];
   endfunction

endpackage

FILE: src/word_suffix_class_counter_core.sv
// top level: input register, suffix table, word logic and result register
// a sentence-ending whitespace item passes through the input and result registers
// throughput: one item per clock; the input stalls only while a finished result
//   is held by rsp_stall and the waiting item would produce another one
// reset (synchronous): clears table valid bits, word state, counters and both
//   pipeline valids
module word_suffix_class_counter_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [7:0]                    req_text_byte,
   input  logic [wscc_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic                          req_entry_valid,
   input  logic [wscc_pkg::CLASS_W-1:0]  req_entry_class,
   input  logic [wscc_pkg::LEN_W-1:0]    req_entry_length,
   input  logic [wscc_pkg::LETTERS_W-1:0] req_entry_letters,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [wscc_pkg::TOTAL_W-1:0]  rsp_noun_total,
   output logic [wscc_pkg::TOTAL_W-1:0]  rsp_verb_total,
   output logic [wscc_pkg::TOTAL_W-1:0]  rsp_adjective_total
);
   import wscc_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic               in_cmd_ff;
   logic [7:0]         in_byte_ff;
   logic [INDEX_W-1:0] in_index_ff;
   entry_type          in_entry_ff;
   entry_type          req_entry;

   logic               out_valid_ff, out_valid_in;
   logic [TOTAL_W-1:0] noun_ff, verb_ff, adj_ff;

   tail_type           tail;
   totals_type         totals;
   logic [2:0]         class_hit;
   logic               emit;
   logic               out_free;
   logic               proceed;
   logic               text_step;
   logic               load_go;
   logic               accept;

   assign req_entry.valid   = req_entry_valid;
   assign req_entry.cls     = req_entry_class;
   assign req_entry.len     = req_entry_length;
   assign req_entry.letters = req_entry_letters;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign text_step = in_valid_ff && (in_cmd_ff == CMD_TEXT);
   assign load_go   = in_valid_ff && (in_cmd_ff == CMD_LOAD);
   assign proceed   = !emit || out_free;
   assign req_stall = in_valid_ff && !proceed;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit && proceed) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff   <= req_cmd;
         in_byte_ff  <= req_text_byte;
         in_index_ff <= req_entry_index;
         in_entry_ff <= req_entry;
      end
      if (emit && proceed) begin
         noun_ff <= fit_total(totals.noun);
         verb_ff <= fit_total(totals.verb);
         adj_ff  <= fit_total(totals.adjective);
      end
   end

   wscc_table u_table (
      .clock      (clock),
      .reset      (reset),
      .load_go    (load_go),
      .load_index (in_index_ff),
      .load_entry (in_entry_ff),
      .tail       (tail),
      .class_hit  (class_hit)
   );

   wscc_word u_word (
      .clock      (clock),
      .reset      (reset),
      .step_valid (text_step),
      .commit     (proceed),
      .text_byte  (in_byte_ff),
      .class_hit  (class_hit),
      .tail       (tail),
      .emit       (emit),
      .totals     (totals)
   );

   assign rsp_valid           = out_valid_ff;
   assign rsp_noun_total      = noun_ff;
   assign rsp_verb_total      = verb_ff;
   assign rsp_adjective_total = adj_ff;

endmodule

FILE: src/wscc_table.sv
// suffix table storage and parallel suffix match per word class
module wscc_table (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_go,
   input  logic [wscc_pkg::INDEX_W-1:0] load_index,
   input  wscc_pkg::entry_type load_entry,
   input  wscc_pkg::tail_type  tail,
   output logic [2:0]          class_hit
);
   import wscc_pkg::*;

   logic      valid_ff [TABLE_DEPTH];
   entry_type slot_ff  [TABLE_DEPTH];
   logic      slot_hit [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (load_go && (int'(load_index) == i)) begin
            valid_ff[i] <= load_entry.valid;
         end
         if (load_go && (int'(load_index) == i)) begin
            slot_ff[i] <= load_entry;
         end
      end
   end

   always_comb begin
      logic [TAIL_W-1:0] ref_letters;
      logic              same;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         ref_letters = fit_letters(slot_ff[i].letters);
         same = 1'b1;
         for (int k = 0; k < MAX_SUFFIX; k++) begin
            if ((k < int'(slot_ff[i].len)) &&
                (ref_letters[k*CODE_BITS +: CODE_BITS] !=
                 tail.letters[k*CODE_BITS +: CODE_BITS])) begin
               same = 1'b0;
            end
         end
         slot_hit[i] = valid_ff[i] && same && (slot_ff[i].len != '0) &&
                       (CMP_W'(slot_ff[i].len) <= CMP_W'(MAX_SUFFIX)) &&
                       (CMP_W'(slot_ff[i].len) <= CMP_W'(tail.seen));
      end
   end

   always_comb begin
      class_hit = 3'b000;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (slot_hit[i] && (slot_ff[i].cls == CLASS_NOUN)) class_hit[0] = 1'b1;
         if (slot_hit[i] && (slot_ff[i].cls == CLASS_VERB)) class_hit[1] = 1'b1;
         if (slot_hit[i] && (slot_ff[i].cls == CLASS_ADJECTIVE)) class_hit[2] = 1'b1;
      end
   end

endmodule

FILE: src/wscc_word.sv
// word tracking, letter tail and saturating class counters
module wscc_word (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_valid,
   input  logic                 commit,
   input  logic [7:0]           text_byte,
   input  logic [2:0]           class_hit,
   output wscc_pkg::tail_type   tail,
   output logic                 emit,
   output wscc_pkg::totals_type totals
);
   import wscc_pkg::*;

   logic [TAIL_W-1:0]      tail_ff, tail_in;
   logic [SEEN_W-1:0]      seen_ff, seen_in;
   logic                   inside_ff, inside_in;
   logic                   dot_ff, dot_in;
   logic [COUNT_WIDTH-1:0] noun_ff, noun_in;
   logic [COUNT_WIDTH-1:0] verb_ff, verb_in;
   logic [COUNT_WIDTH-1:0] adj_ff, adj_in;
   logic                   blank;
   logic [7:0]             folded;
   logic                   letter;
   logic [CODE_BITS-1:0]   code;
   logic [7:0]             offset;

   function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v,
                                                  input logic hit);
      return (hit && (v != '1)) ? v + 1'b1 : v;
   endfunction

   assign blank  = is_blank(text_byte);
   assign folded = ((text_byte >= CHAR_UPPER_A) && (text_byte <= CHAR_UPPER_Z)) ?
                   (text_byte | CHAR_SPACE) : text_byte;
   assign letter = (folded >= CHAR_LOWER_A) && (folded <= CHAR_LOWER_Z);
   assign offset = folded - CHAR_LOWER_A;
   assign code   = offset[CODE_BITS-1:0];

   assign tail.letters = tail_ff;
   assign tail.seen    = seen_ff;

   assign emit = step_valid && blank && inside_ff && dot_ff;

   assign totals.noun      = bump(noun_ff, class_hit[0]);
   assign totals.verb      = bump(verb_ff, class_hit[1]);
   assign totals.adjective = bump(adj_ff, class_hit[2]);

   always_comb begin
      tail_in   = tail_ff;
      seen_in   = seen_ff;
      inside_in = inside_ff;
      dot_in    = dot_ff;
      noun_in   = noun_ff;
      verb_in   = verb_ff;
      adj_in    = adj_ff;
      if (step_valid && commit) begin
         if (blank) begin
            if (inside_ff) begin
               if (dot_ff) begin
                  noun_in = '0;
                  verb_in = '0;
                  adj_in  = '0;
               end else begin
                  noun_in = totals.noun;
                  verb_in = totals.verb;
                  adj_in  = totals.adjective;
               end
            end
            tail_in   = '0;
            seen_in   = '0;
            inside_in = 1'b0;
            dot_in    = 1'b0;
         end else begin
            inside_in = 1'b1;
            dot_in    = (text_byte == CHAR_DOT);
            if (letter) begin
               tail_in = TAIL_W'({tail_ff, code});
               if (seen_ff != SEEN_W'(MAX_SUFFIX)) begin
                  seen_in = seen_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff   <= '0;
         seen_ff   <= '0;
         inside_ff <= 1'b0;
         dot_ff    <= 1'b0;
         noun_ff   <= '0;
         verb_ff   <= '0;
         adj_ff    <= '0;
      end else begin
         tail_ff   <= tail_in;
         seen_ff   <= seen_in;
         inside_ff <= inside_in;
         dot_ff    <= dot_in;
         noun_ff   <= noun_in;
         verb_ff   <= verb_in;
         adj_ff    <= adj_in;
      end
   end

endmodule

FILE: src/wscc_checker.sv
// port-level checks of the word suffix class counter, bound to the top level
module wscc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_cmd,
   input logic [7:0]                    req_text_byte,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [wscc_pkg::TOTAL_W-1:0]  rsp_noun_total,
   input logic [wscc_pkg::TOTAL_W-1:0]  rsp_verb_total,
   input logic [wscc_pkg::TOTAL_W-1:0]  rsp_adjective_total
);
   import wscc_pkg::*;

   logic blank_text_accept;

   assign blank_text_accept = req_valid && !req_stall && (req_cmd == CMD_TEXT) &&
                              is_blank(req_text_byte);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_noun_total) &&
         $stable(rsp_verb_total) && $stable(rsp_adjective_total))
      else $error("held result changed");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(blank_text_accept, 2))
      else $error("result without a whitespace item two cycles earlier");

endmodule

bind word_suffix_class_counter_core wscc_checker u_wscc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_cmd             (req_cmd),
   .req_text_byte       (req_text_byte),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_noun_total      (rsp_noun_total),
   .rsp_verb_total      (rsp_verb_total),
   .rsp_adjective_total (rsp_adjective_total)
);
